/* hw/rtl/vcfs_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the voxel cube frame and layer scanner
// no dependencies

package vcfs_pkg;

	localparam int unsigned EDGE_LENGTH_DEF = 3;
	localparam int unsigned COL_W = 9;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_BOX    = 3'd1,
		CMD_READ   = 3'd2,
		CMD_SHELL  = 3'd3,
		CMD_EDGES  = 3'd4,
		CMD_SHIFT  = 3'd5,
		CMD_MIRROR = 3'd6,
		CMD_COPY   = 3'd7
	} cmd_e_t;

	typedef enum logic [1:0] {
		ACT_OFF    = 2'd0,
		ACT_ON     = 2'd1,
		ACT_TOGGLE = 2'd2,
		ACT_KEEP   = 2'd3
	} act_e_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2,
		AXIS_N = 2'd3
	} axis_e_t;

	typedef enum logic {
		ST_EMPTY = 1'b0,
		ST_FULL  = 1'b1
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic exec;
	} dp_cmd_t;

endpackage

/* hw/rtl/vcfs_ctrl.sv */
`timescale 1ns / 1ps
// handshake controller: one result slot between input and output side
// depends on vcfs_pkg

module vcfs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output vcfs_pkg::dp_cmd_t dp_cmd
);
	import vcfs_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		out_valid   = 1'b0;
		in_ready    = 1'b0;
		dp_cmd.exec = 1'b0;
		case (state_q)
			ST_EMPTY: begin
				in_ready    = 1'b1;
				dp_cmd.exec = in_valid;
				if (in_valid) begin
					state_nxt = ST_FULL;
				end
			end
			ST_FULL: begin
				out_valid   = 1'b1;
				// slot frees on the output transfer, so a new item may enter the same edge
				in_ready    = out_ready;
				dp_cmd.exec = in_valid && out_ready;
				if (out_ready && !in_valid) begin
					state_nxt = ST_EMPTY;
				end
			end
			default: begin
				state_nxt = ST_EMPTY;
			end
		endcase
	end

endmodule

/* hw/rtl/vcfs_datapath.sv */
`timescale 1ns / 1ps
// frame store, scan layer and column latch with per-voxel update logic
// depends on vcfs_pkg

module vcfs_datapath #(
	parameter int unsigned EDGE_LENGTH = vcfs_pkg::EDGE_LENGTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  vcfs_pkg::dp_cmd_t         dp_cmd,
	input  logic [2:0]                cmd,
	input  logic [1:0]                x_lo,
	input  logic [1:0]                x_hi,
	input  logic [1:0]                y_lo,
	input  logic [1:0]                y_hi,
	input  logic [1:0]                z_lo,
	input  logic [1:0]                z_hi,
	input  logic [1:0]                action,
	input  logic [1:0]                axis,
	input  logic signed [2:0]         shift_step,
	input  logic                      wrap_mode,
	output logic [1:0]                active_layer,
	output logic [vcfs_pkg::COL_W-1:0] column_pattern,
	output logic                      led_value
);
	import vcfs_pkg::*;

	localparam int unsigned CW = $clog2(EDGE_LENGTH);
	localparam logic [2:0] MAXC = 3'(EDGE_LENGTH - 1);

	typedef logic [EDGE_LENGTH-1:0][EDGE_LENGTH-1:0][EDGE_LENGTH-1:0] frame_t;

	function automatic logic [CW-1:0] sat(input logic [1:0] v);
		return ({1'b0, v} > MAXC) ? CW'(MAXC) : CW'(v);
	endfunction

	function automatic logic apply_act(input logic v, input act_e_t a);
		logic r;
		case (a)
			ACT_OFF:    r = 1'b0;
			ACT_ON:     r = 1'b1;
			ACT_TOGGLE: r = ~v;
			default:    r = v;
		endcase
		return r;
	endfunction

	frame_t            frame_q;
	frame_t            frame_nxt;
	logic [CW-1:0]     layer_q;
	logic [CW-1:0]     layer_nxt;
	logic [COL_W-1:0]  columns_q;
	logic [COL_W-1:0]  columns_nxt;
	logic              led_q;

	cmd_e_t            cmd_e;
	act_e_t            act_e;
	axis_e_t           axis_e;
	logic [CW-1:0]     xl, xh, yl, yh, zl, zh;
	logic [CW-1:0]     src_c [EDGE_LENGTH];
	logic              src_ok [EDGE_LENGTH];

	assign cmd_e  = cmd_e_t'(cmd);
	assign act_e  = act_e_t'(action);
	assign axis_e = axis_e_t'(axis);
	assign xl = sat(x_lo);
	assign xh = sat(x_hi);
	assign yl = sat(y_lo);
	assign yh = sat(y_hi);
	assign zl = sat(z_lo);
	assign zh = sat(z_hi);

	// source coordinate along the shift axis for each destination coordinate
	always_comb begin
		int s0;
		int s;
		for (int d = 0; d < EDGE_LENGTH; d++) begin
			s0 = d - int'(shift_step);
			s  = s0;
			if (s < 0) s = s + EDGE_LENGTH;
			if (s < 0) s = s + EDGE_LENGTH;
			if (s >= EDGE_LENGTH) s = s - EDGE_LENGTH;
			if (s >= EDGE_LENGTH) s = s - EDGE_LENGTH;
			src_c[d]  = CW'(s);
			src_ok[d] = wrap_mode || (s0 >= 0 && s0 < EDGE_LENGTH);
		end
	end

	for (genvar gx = 0; gx < EDGE_LENGTH; gx++) begin : g_x
		for (genvar gy = 0; gy < EDGE_LENGTH; gy++) begin : g_y
			for (genvar gz = 0; gz < EDGE_LENGTH; gz++) begin : g_z
				localparam int unsigned BX = (gx == 0 || gx == EDGE_LENGTH - 1) ? 1 : 0;
				localparam int unsigned BY = (gy == 0 || gy == EDGE_LENGTH - 1) ? 1 : 0;
				localparam int unsigned BZ = (gz == 0 || gz == EDGE_LENGTH - 1) ? 1 : 0;
				localparam int unsigned BORDERS = BX + BY + BZ;
				localparam int unsigned MX = EDGE_LENGTH - 1 - gx;
				localparam int unsigned MY = EDGE_LENGTH - 1 - gy;
				localparam int unsigned MZ = EDGE_LENGTH - 1 - gz;

				logic cur;
				logic box_hit;
				logic shifted;
				logic mirrored;

				assign cur = frame_q[gx][gy][gz];
				assign box_hit = (CW'(gx) >= xl) && (CW'(gx) <= xh)
					&& (CW'(gy) >= yl) && (CW'(gy) <= yh)
					&& (CW'(gz) >= zl) && (CW'(gz) <= zh);

				always_comb begin
					case (axis_e)
						AXIS_X:  shifted = src_ok[gx] && frame_q[src_c[gx]][gy][gz];
						AXIS_Y:  shifted = src_ok[gy] && frame_q[gx][src_c[gy]][gz];
						default: shifted = src_ok[gz] && frame_q[gx][gy][src_c[gz]];
					endcase
				end

				always_comb begin
					case (axis_e)
						AXIS_X:  mirrored = frame_q[MX][gy][gz];
						AXIS_Y:  mirrored = frame_q[gx][MY][gz];
						AXIS_Z:  mirrored = frame_q[gx][gy][MZ];
						default: mirrored = cur;
					endcase
				end

				always_comb begin
					case (cmd_e)
						CMD_BOX:    frame_nxt[gx][gy][gz] = box_hit ? apply_act(cur, act_e) : cur;
						CMD_SHELL:  frame_nxt[gx][gy][gz] =
							(BORDERS >= 1) ? apply_act(cur, act_e) : cur;
						CMD_EDGES:  frame_nxt[gx][gy][gz] =
							(BORDERS >= 2) ? apply_act(cur, act_e) : cur;
						CMD_SHIFT:  frame_nxt[gx][gy][gz] = shifted;
						CMD_MIRROR: frame_nxt[gx][gy][gz] = mirrored;
						CMD_COPY:   frame_nxt[gx][gy][gz] =
							(CW'(gx) == xh) ? frame_q[xl][gy][gz] : cur;
						default:    frame_nxt[gx][gy][gz] = cur;
					endcase
				end
			end
		end
	end

	assign layer_nxt = (layer_q == CW'(EDGE_LENGTH - 1)) ? '0 : layer_q + CW'(1);

	// column bit y*EDGE_LENGTH+z of the next layer, kept to the low nine
	for (genvar gi = 0; gi < COL_W; gi++) begin : g_col
		if (gi < EDGE_LENGTH * EDGE_LENGTH) begin : g_on
			assign columns_nxt[gi] = frame_q[layer_nxt][gi / EDGE_LENGTH][gi % EDGE_LENGTH];
		end else begin : g_off
			assign columns_nxt[gi] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= '0;
			layer_q   <= '0;
			columns_q <= '0;
			led_q     <= 1'b0;
		end else if (dp_cmd.exec) begin
			frame_q <= frame_nxt;
			led_q   <= (cmd_e == CMD_READ) ? frame_q[xl][yl][zl] : 1'b0;
			if (cmd_e == CMD_TICK) begin
				layer_q   <= layer_nxt;
				columns_q <= columns_nxt;
			end
		end
	end

	assign active_layer   = 2'(layer_q);
	assign column_pattern = columns_q;
	assign led_value      = led_q;

endmodule

/* hw/rtl/voxel_cube_frame_and_scan_top.sv */
`timescale 1ns / 1ps
// voxel cube frame store and layer scanner, top level
// the result of a command is valid the cycle after its input transfer
// throughput: one command per cycle while out_ready is high; a single result
// register sits between the sides, and all voxels of the frame update together
// reset: arst_n clears the frame, the scan layer, the column latch and the result slot
// depends on vcfs_pkg, vcfs_ctrl, vcfs_datapath

module voxel_cube_frame_and_scan_top #(
	parameter int unsigned EDGE_LENGTH = vcfs_pkg::EDGE_LENGTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 cmd,
	input  logic [1:0]                 x_lo,
	input  logic [1:0]                 x_hi,
	input  logic [1:0]                 y_lo,
	input  logic [1:0]                 y_hi,
	input  logic [1:0]                 z_lo,
	input  logic [1:0]                 z_hi,
	input  logic [1:0]                 action,
	input  logic [1:0]                 axis,
	input  logic signed [2:0]          shift_step,
	input  logic                       wrap_mode,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 active_layer,
	output logic [vcfs_pkg::COL_W-1:0] column_pattern,
	output logic                       led_value
);
	import vcfs_pkg::*;

	dp_cmd_t dp_cmd;

	vcfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_cmd    (dp_cmd)
	);

	vcfs_datapath #(
		.EDGE_LENGTH (EDGE_LENGTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.dp_cmd         (dp_cmd),
		.cmd            (cmd),
		.x_lo           (x_lo),
		.x_hi           (x_hi),
		.y_lo           (y_lo),
		.y_hi           (y_hi),
		.z_lo           (z_lo),
		.z_hi           (z_hi),
		.action         (action),
		.axis           (axis),
		.shift_step     (shift_step),
		.wrap_mode      (wrap_mode),
		.active_layer   (active_layer),
		.column_pattern (column_pattern),
		.led_value      (led_value)
	);

endmodule

/* hw/rtl/vcfs_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the voxel cube top level, attached by bind
// depends on vcfs_pkg and voxel_cube_frame_and_scan_top

module vcfs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [2:0]                 cmd,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [1:0]                 active_layer,
	input logic [vcfs_pkg::COL_W-1:0] column_pattern,
	input logic                       led_value
);
	import vcfs_pkg::*;

	// every input transfer shows its result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after input transfer");

	// an empty result slot never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no pending result");

	// only a read command can raise the voxel value
	a_led_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd != CMD_READ |=> !led_value)
		else $error("voxel value set by a non-read command");

	// layer and columns move only on a tick
	a_scan_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd != CMD_TICK |=> $stable(active_layer)
		&& $stable(column_pattern))
		else $error("scan state changed without a tick");

	// a held result keeps its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(led_value))
		else $error("pending result changed during stall");

endmodule

bind voxel_cube_frame_and_scan_top vcfs_checker u_vcfs_checker (.*);
